### design/mmcs_pkg.sv
`timescale 1ns / 1ps

package mmcs_pkg;

  // Width of one color sample and the largest level it can hold.
  localparam int unsigned PixW = 8;
  localparam logic [PixW-1:0] PixMax = {PixW{1'b1}};
  localparam logic [PixW-1:0] PixMin = '0;

  // Red, green and blue each get a lane; alpha bypasses the lanes.
  localparam int unsigned NumLanes = 3;

  // One quotient bit per divider step.
  localparam int unsigned DivSteps = PixW;
  localparam int unsigned CntW = $clog2(DivSteps);

  // Pass codes carried in the op field.
  localparam logic OpMeasure = 1'b0;
  localparam logic OpStretch = 1'b1;

  // What the top level tells every lane on an accepted beat.
  typedef struct packed {
    logic measure;
    logic stretch;
    logic clear;
  } lane_cmd_t;

endpackage

### design/mmcs_pix_in_if.sv
`timescale 1ns / 1ps

interface mmcs_pix_in_if;
  logic                        valid;
  logic                        ready;
  logic                        op;
  logic                        start_frame;
  logic [mmcs_pkg::PixW-1:0]   red;
  logic [mmcs_pkg::PixW-1:0]   green;
  logic [mmcs_pkg::PixW-1:0]   blue;
  logic [mmcs_pkg::PixW-1:0]   alpha;

  modport source (
    output valid, op, start_frame, red, green, blue, alpha,
    input  ready
  );

  modport sink (
    input  valid, op, start_frame, red, green, blue, alpha,
    output ready
  );
endinterface

### design/mmcs_pix_out_if.sv
`timescale 1ns / 1ps

interface mmcs_pix_out_if;
  logic                        valid;
  logic                        ready;
  logic [mmcs_pkg::PixW-1:0]   out_red;
  logic [mmcs_pkg::PixW-1:0]   out_green;
  logic [mmcs_pkg::PixW-1:0]   out_blue;
  logic [mmcs_pkg::PixW-1:0]   out_alpha;

  modport source (
    output valid, out_red, out_green, out_blue, out_alpha,
    input  ready
  );

  modport sink (
    input  valid, out_red, out_green, out_blue, out_alpha,
    output ready
  );
endinterface

### design/minmax_contrast_stretch.sv
`timescale 1ns / 1ps

// Channel  Dir  Beat contents
// -------  ---  ---------------------------------------------------------
// pix_i    in   op, start_frame, red, green, blue, alpha
// pix_o    out  out_red, out_green, out_blue, out_alpha (stretch beats only)
//
// A measure beat is absorbed at its accepting edge; the next beat may follow at once.
// A stretch beat is valid on pix_o after its accepting edge, eight divider steps
// and one output load; if every lane is zero or saturated, after the output load alone.
// The input stalls until the lanes hand their result to the output register,
// which holds it while pix_o stalls. Reset loads every minimum with 255 and
// every maximum with 0, empties the output register and idles the dividers.
module minmax_contrast_stretch (
  input  logic           clk_i,
  input  logic           rst_ni,
  mmcs_pix_in_if.sink    pix_i,
  mmcs_pix_out_if.source pix_o
);

  localparam int unsigned N = mmcs_pkg::NumLanes;

  logic                                 accept;
  mmcs_pkg::lane_cmd_t                  cmd;
  logic [N-1:0]                         lane_busy;
  logic [N-1:0]                         lane_done;
  logic [N-1:0][mmcs_pkg::PixW-1:0]     lane_res;
  logic [N-1:0][mmcs_pkg::PixW-1:0]     lane_pix;
  logic                                 take;
  logic [mmcs_pkg::PixW-1:0]            alpha_q;

  // The lanes share one control flow, so any busy lane blocks the input.
  assign pix_i.ready = ~|lane_busy;
  assign accept      = pix_i.valid && pix_i.ready;

  // The start flag only matters on measure beats.
  always_comb begin
    cmd.measure = accept && (pix_i.op == mmcs_pkg::OpMeasure);
    cmd.stretch = accept && (pix_i.op == mmcs_pkg::OpStretch);
    cmd.clear   = pix_i.start_frame;
  end

  assign lane_pix[0] = pix_i.red;
  assign lane_pix[1] = pix_i.green;
  assign lane_pix[2] = pix_i.blue;

  // Alpha does not go through a lane; it is parked here for the merge.
  always_ff @(posedge clk_i) begin
    if (cmd.stretch) begin
      alpha_q <= pix_i.alpha;
    end
  end

  for (genvar g = 0; g < N; g++) begin : g_lane
    mmcs_lane u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cmd_i  (cmd),
      .pix_i  (lane_pix[g]),
      .take_i (take),
      .busy_o (lane_busy[g]),
      .done_o (lane_done[g]),
      .res_o  (lane_res[g])
    );
  end

  mmcs_merge u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .done_i  (lane_done),
    .res_i   (lane_res),
    .alpha_i (alpha_q),
    .take_o  (take),
    .pix_o   (pix_o)
  );

endmodule

### design/mmcs_lane.sv
`timescale 1ns / 1ps

// One color channel: running min/max tracking plus a restoring divider
// that produces one quotient bit per cycle.
module mmcs_lane (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  mmcs_pkg::lane_cmd_t       cmd_i,
  input  logic [mmcs_pkg::PixW-1:0] pix_i,
  input  logic                      take_i,
  output logic                      busy_o,
  output logic                      done_o,
  output logic [mmcs_pkg::PixW-1:0] res_o
);

  localparam int unsigned W = mmcs_pkg::PixW;

  logic [W-1:0]                  min_q, min_d, max_q, max_d;
  logic [W-1:0]                  base_min, base_max;
  logic                          run_q, run_d, done_q, done_d;
  logic [mmcs_pkg::CntW-1:0]     cnt_q, cnt_d;
  logic [W-1:0]                  rem_q, rem_d, quo_q, quo_d, range_q, range_d;
  logic [W-1:0]                  range_new, offset_new;
  logic [2*W-1:0]                num_new;
  logic                          zero_case, sat_case;
  logic [W:0]                    rem_sh, rem_sub;
  logic                          ge;

  // Measure pass: optional reload, then fold the sample in.
  always_comb begin
    base_min = cmd_i.clear ? mmcs_pkg::PixMax : min_q;
    base_max = cmd_i.clear ? mmcs_pkg::PixMin : max_q;
    min_d    = min_q;
    max_d    = max_q;
    if (cmd_i.measure) begin
      min_d = (pix_i < base_min) ? pix_i : base_min;
      max_d = (pix_i > base_max) ? pix_i : base_max;
    end
  end

  // Stretch setup. The numerator is 255 * offset; since offset < range the
  // quotient fits in W bits and the top half of the numerator is already
  // below the divisor, so the divider starts from it.
  always_comb begin
    range_new  = max_q - min_q;
    offset_new = pix_i - min_q;
    zero_case  = (max_q <= min_q) || (pix_i <= min_q);
    sat_case   = offset_new >= range_new;
    num_new    = {offset_new, {W{1'b0}}} - {{W{1'b0}}, offset_new};
  end

  always_comb begin
    rem_sh  = {rem_q, quo_q[W-1]};
    rem_sub = rem_sh - {1'b0, range_q};
    ge      = rem_sh >= {1'b0, range_q};
  end

  always_comb begin
    run_d   = run_q;
    done_d  = done_q;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    range_d = range_q;
    if (cmd_i.stretch) begin
      range_d = range_new;
      cnt_d   = '0;
      if (zero_case) begin
        quo_d  = mmcs_pkg::PixMin;
        done_d = 1'b1;
      end else if (sat_case) begin
        quo_d  = mmcs_pkg::PixMax;
        done_d = 1'b1;
      end else begin
        rem_d = num_new[2*W-1:W];
        quo_d = num_new[W-1:0];
        run_d = 1'b1;
      end
    end else if (run_q) begin
      rem_d = ge ? rem_sub[W-1:0] : rem_sh[W-1:0];
      quo_d = {quo_q[W-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == mmcs_pkg::CntW'(mmcs_pkg::DivSteps - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end else if (take_i) begin
      done_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q  <= mmcs_pkg::PixMax;
      max_q  <= mmcs_pkg::PixMin;
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      min_q  <= min_d;
      max_q  <= max_d;
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q   <= rem_d;
    quo_q   <= quo_d;
    range_q <= range_d;
  end

  assign busy_o = run_q | done_q;
  assign done_o = done_q;
  assign res_o  = quo_q;

endmodule

### design/mmcs_merge.sv
`timescale 1ns / 1ps

// Gathers the lane quotients and the held alpha into the output register.
module mmcs_merge (
  input  logic                                               clk_i,
  input  logic                                               rst_ni,
  input  logic [mmcs_pkg::NumLanes-1:0]                      done_i,
  input  logic [mmcs_pkg::NumLanes-1:0][mmcs_pkg::PixW-1:0] res_i,
  input  logic [mmcs_pkg::PixW-1:0]                          alpha_i,
  output logic                                               take_o,
  mmcs_pix_out_if.source                                     pix_o
);

  logic                      valid_q, valid_d;
  logic [mmcs_pkg::PixW-1:0] red_q, green_q, blue_q, alpha_q;

  // A lane that skipped its divider holds its done flag until the dividing
  // lanes finish, so all results are taken together.
  assign take_o = (&done_i) && (!valid_q || pix_o.ready);

  always_comb begin
    valid_d = valid_q;
    if (take_o) begin
      valid_d = 1'b1;
    end else if (pix_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      red_q   <= res_i[0];
      green_q <= res_i[1];
      blue_q  <= res_i[2];
      alpha_q <= alpha_i;
    end
  end

  assign pix_o.valid     = valid_q;
  assign pix_o.out_red   = red_q;
  assign pix_o.out_green = green_q;
  assign pix_o.out_blue  = blue_q;
  assign pix_o.out_alpha = alpha_q;

endmodule
